// ----- sv/psw_pkg.sv -----
package psw_pkg;

  localparam int MAX_CORNERS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;

  // Width used for saturating sums and differences of 32-bit coordinates.
  localparam int SAT_W = 66;
  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(32'sh7FFFFFFF);
  localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(32'sh80000000);

  localparam logic signed [31:0] X_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] X_MIN = 32'sh80000000;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ROW_START,
    PH_IN_ROW,
    PH_DONE
  } phase_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_BUILD_INIT,
    DP_RD_I,
    DP_RD_J,
    DP_CAP_J,
    DP_EDGE_FIX,
    DP_DIV_SLOPE,
    DP_SLOPE_CAP,
    DP_MUL,
    DP_EDGE_WR,
    DP_ROW_INIT,
    DP_SET_DONE,
    DP_CLAMP,
    DP_L_RD,
    DP_L_INC,
    DP_R_RD,
    DP_R_INC,
    DP_CUT_RD_A,
    DP_CUT_RD_B,
    DP_CUT_FIX,
    DP_DIV_CUT,
    DP_CUT_CAP,
    DP_ROW_SET,
    DP_ROW_ADV,
    DP_EMIT_PT,
    DP_EMIT_DONE
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_B_RD_I,
    S_B_RD_J,
    S_B_CAP_J,
    S_B_DEC,
    S_B_WAIT,
    S_B_MUL,
    S_B_WR,
    S_ROW_INIT,
    S_DISPATCH,
    S_L_RD,
    S_L_CHK,
    S_R_RD,
    S_R_CHK,
    S_C_DEC,
    S_C_WAIT,
    S_C_RD_B,
    S_ROW_SET,
    S_EMIT_PT,
    S_EMIT_DONE
  } state_t;

  typedef struct packed {
    logic               vertical;
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
  } edge_t;

  typedef struct packed {
    phase_t phase;
    logic   row_ge_top;
    logic   edge_fixed;
    logic   ei_last;
    logic   div_done;
    logic   div_busy;
    logic   l_more;
    logic   r_more;
    logic   cut_fixed;
    logic   cut_b;
    logic   in_row_go;
    logic   out_free;
  } dp_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = X_MAX;
    end else if (v < SAT_LO) begin
      r = X_MIN;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

endpackage

// ----- sv/polygon_sweep_route_points.sv -----
// Boustrophedon route generator over a convex polygon. A load beat (op 0) stores one vertex
// and produces no result. A request beat (op 1) returns one route point, or a done beat
// once the sweep is over. A point inside a row goes from dispatch to emit, and emit waits
// while the output is stalled. A request that opens a new row also walks both vertex chains
// and cuts each chain's edge on the shared serial divider, bar a vertical or horizontal edge.
// The first request after a load builds the edge table over all MAX_CORNERS slots on the
// same divider. Configuration must be written only while the block is idle.
module polygon_sweep_route_points #(
  parameter int MAX_CORNERS = psw_pkg::MAX_CORNERS_DEF,
  parameter int FRAC_BITS   = psw_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic [3:0]         vertex_slot,
  input  logic signed [31:0] vertex_x,
  input  logic signed [31:0] vertex_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] route_x,
  output logic signed [31:0] route_y,
  output logic [31:0]        route_index,
  output logic               route_done
);
  import psw_pkg::*;

  logic [30:0] point_spacing;
  logic [4:0]  vertex_count;
  dp_op_t      cmd;
  dp_status_t  status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_spacing <= 31'd65536;
      vertex_count  <= 5'd4;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        vertex_count <= pwdata[4:0];
      end else begin
        point_spacing <= pwdata[30:0];
      end
    end
  end

  assign prdata = paddr[2] ? {27'd0, vertex_count} : {1'b0, point_spacing};

  psw_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .op      (op),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  psw_datapath #(
    .MAX_CORNERS(MAX_CORNERS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .point_spacing(point_spacing),
    .vertex_count (vertex_count),
    .vertex_slot  (vertex_slot),
    .vertex_x     (vertex_x),
    .vertex_y     (vertex_y),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .route_x      (route_x),
    .route_y      (route_y),
    .route_index  (route_index),
    .route_done   (route_done)
  );

`ifndef ASSERT_OFF
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && route_done |-> route_x == 32'sd0 && route_y == 32'sd0)
    else $error("done beat carries a nonzero point");

  a_req_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && op |=> in_stall)
    else $error("request beat did not occupy the sequencer");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    (cmd == DP_DIV_SLOPE || cmd == DP_DIV_CUT) |-> !status.div_busy)
    else $error("divider started while busy");
`endif

endmodule

// ----- sv/psw_div.sv -----
module psw_div #(
  parameter int FRAC_BITS = psw_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [32:0] num,
  input  logic signed [32:0] den,
  output logic               busy,
  output logic               done,
  output logic signed [31:0] quot
);
  import psw_pkg::*;

  // Quotient of (num * 2^FRAC_BITS) / den, truncated toward zero and saturated.
  localparam int DW = 33 + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] acc;
  logic [32:0]   rem;
  logic [32:0]   dmag;
  logic          neg;
  logic [CW-1:0] cnt;

  logic [32:0] num_mag;
  logic [32:0] den_mag;
  logic [33:0] rem_sh;
  logic [33:0] rem_diff;
  logic        qbit;

  assign num_mag  = num[32] ? 33'(-num) : 33'(num);
  assign den_mag  = den[32] ? 33'(-den) : 33'(den);
  assign rem_sh   = {rem, acc[DW-1]};
  assign rem_diff = rem_sh - {1'b0, dmag};
  assign qbit     = (rem_sh >= {1'b0, dmag});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= {num_mag, {FRAC_BITS{1'b0}}};
      rem  <= '0;
      dmag <= den_mag;
      neg  <= num[32] ^ den[32];
    end else if (busy) begin
      acc <= {acc[DW-2:0], qbit};
      rem <= qbit ? rem_diff[32:0] : rem_sh[32:0];
    end
  end

  always_comb begin
    if (neg) begin
      if (acc > DW'(33'h080000000)) begin
        quot = X_MIN;
      end else begin
        quot = -$signed(acc[31:0]);
      end
    end else begin
      if (acc > DW'(33'h07FFFFFFF)) begin
        quot = X_MAX;
      end else begin
        quot = $signed(acc[31:0]);
      end
    end
  end

endmodule

// ----- sv/psw_datapath.sv -----
module psw_datapath #(
  parameter int MAX_CORNERS = psw_pkg::MAX_CORNERS_DEF,
  parameter int FRAC_BITS   = psw_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  psw_pkg::dp_op_t     cmd,
  output psw_pkg::dp_status_t status,
  input  logic [30:0]         point_spacing,
  input  logic [4:0]          vertex_count,
  input  logic [3:0]          vertex_slot,
  input  logic signed [31:0]  vertex_x,
  input  logic signed [31:0]  vertex_y,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  route_x,
  output logic signed [31:0]  route_y,
  output logic [31:0]         route_index,
  output logic                route_done
);
  import psw_pkg::*;

  localparam int IDX_W = $clog2(MAX_CORNERS);
  localparam int CNT_W = $clog2(MAX_CORNERS + 1);
  localparam logic signed [33:0] ONE_FX = 34'sd1 <<< FRAC_BITS;
  localparam logic signed [33:0] ROW_MAX = 34'sd2147483647;

  logic signed [31:0] corner_x [MAX_CORNERS];
  logic signed [31:0] corner_y [MAX_CORNERS];
  edge_t              edge_mem [MAX_CORNERS];

  logic signed [31:0] rd_x, rd_y;
  edge_t              e_rd;
  logic signed [31:0] xi, yi, xj, yj, y0;
  logic [IDX_W-1:0]   ei;
  logic signed [31:0] slope;
  logic signed [63:0] prod;
  logic signed [31:0] xa, xb;
  logic               cut_b;
  logic [IDX_W-1:0]   left_chain_index;
  logic [IDX_W-1:0]   right_chain_offset;
  logic signed [31:0] row_y;
  logic signed [31:0] top_y;
  logic signed [31:0] cursor_x;
  logic signed [31:0] row_limit_x;
  logic               sweep_forward;
  logic [31:0]        point_counter;
  phase_t             sweep_phase;

  logic [CNT_W-1:0]   n;
  logic [IDX_W-1:0]   nm1;
  logic [IDX_W-1:0]   j;
  logic               ei_last_used;
  logic               ei_out;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   e_addr;
  logic [IDX_W-1:0]   le, re;
  logic [IDX_W-1:0]   li_c, li_lo;
  logic signed [31:0] xb_end, yb_end;
  logic signed [32:0] d_s;
  logic signed [32:0] cut_num;
  logic signed [31:0] cut_fix_val;
  logic signed [33:0] row0_next;
  logic signed [33:0] row_step;
  logic               div_start;
  logic signed [32:0] div_num, div_den;
  logic               div_busy, div_done;
  logic signed [31:0] div_q;
  logic               slot_ok;

  always_comb begin
    if (vertex_count < 5'd3) begin
      n = CNT_W'(3);
    end else if (32'(vertex_count) > MAX_CORNERS) begin
      n = CNT_W'(MAX_CORNERS);
    end else begin
      n = CNT_W'(vertex_count);
    end
  end

  assign nm1          = IDX_W'(n - 1'b1);
  assign ei_last_used = (ei == nm1);
  assign j            = ei_last_used ? '0 : ei + 1'b1;
  assign ei_out       = (CNT_W'(ei) >= n);
  assign le           = left_chain_index - 1'b1;
  assign re           = nm1 - right_chain_offset;
  assign li_lo        = (left_chain_index > nm1) ? nm1 : left_chain_index;
  assign li_c         = (li_lo < IDX_W'(1)) ? IDX_W'(1) : li_lo;
  assign xb_end       = ei_last_used ? xi : xj;
  assign yb_end       = ei_last_used ? yi : yj;
  assign d_s          = (point_spacing == '0) ? 33'sd1 : $signed({2'b00, point_spacing});
  assign cut_num      = 33'(row_y) - 33'(e_rd.intercept);
  assign cut_fix_val  = e_rd.vertical ? e_rd.intercept : (cut_num[32] ? X_MIN : X_MAX);
  assign row0_next    = 34'(y0) + ONE_FX;
  assign row_step     = 34'(row_y) + ONE_FX;
  assign slot_ok      = (32'(vertex_slot) < MAX_CORNERS);

  always_comb begin
    unique case (cmd)
      DP_RD_J: rd_addr = j;
      DP_L_RD: rd_addr = left_chain_index;
      DP_R_RD: rd_addr = re;
      default: rd_addr = ei;
    endcase
  end

  assign e_addr = (cmd == DP_CUT_RD_A) ? re : le;

  assign div_start = (cmd == DP_DIV_SLOPE) || (cmd == DP_DIV_CUT);
  assign div_num   = (cmd == DP_DIV_CUT) ? cut_num : 33'(yj) - 33'(yi);
  assign div_den   = (cmd == DP_DIV_CUT) ? 33'(e_rd.slope) : 33'(xj) - 33'(xi);

  psw_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .busy (div_busy),
    .done (div_done),
    .quot (div_q)
  );

  // Vertex store and edge table: one write and one registered read each.
  always_ff @(posedge clk) begin
    if (cmd == DP_LOAD && slot_ok) begin
      corner_x[IDX_W'(vertex_slot)] <= vertex_x;
      corner_y[IDX_W'(vertex_slot)] <= vertex_y;
    end
    rd_x <= corner_x[rd_addr];
    rd_y <= corner_y[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd == DP_EDGE_FIX) begin
      if (ei_out) begin
        edge_mem[ei] <= '0;
      end else begin
        edge_mem[ei] <= '{vertical: 1'b1, slope: 32'sd0, intercept: xi};
      end
    end else if (cmd == DP_EDGE_WR) begin
      edge_mem[ei] <= '{vertical: 1'b0, slope: slope,
                        intercept: sat32(SAT_W'(yb_end) - (SAT_W'(prod) >>> FRAC_BITS))};
    end
    e_rd <= edge_mem[e_addr];
  end

  // Edge build and edge cut working registers.
  always_ff @(posedge clk) begin
    unique case (cmd)
      DP_RD_J: begin
        xi <= rd_x;
        yi <= rd_y;
        if (ei == '0) begin
          y0 <= rd_y;
        end
      end
      DP_CAP_J: begin
        xj <= rd_x;
        yj <= rd_y;
      end
      DP_SLOPE_CAP: slope <= div_q;
      DP_MUL: prod <= slope * xb_end;
      DP_CUT_FIX: begin
        if (cut_b) begin
          xb <= cut_fix_val;
        end else begin
          xa <= cut_fix_val;
        end
      end
      DP_CUT_CAP: begin
        if (cut_b) begin
          xb <= div_q;
        end else begin
          xa <= div_q;
        end
      end
      default: begin
      end
    endcase
  end

  // A new result beat takes priority over retiring the one just accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd == DP_EMIT_PT || cmd == DP_EMIT_DONE) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ei                 <= '0;
      cut_b              <= 1'b0;
      top_y              <= X_MIN;
      row_y              <= '0;
      left_chain_index   <= IDX_W'(1);
      right_chain_offset <= '0;
      cursor_x           <= '0;
      row_limit_x        <= '0;
      sweep_forward      <= 1'b1;
      point_counter      <= '0;
      sweep_phase        <= PH_IDLE;
    end else begin
      unique case (cmd)
        DP_LOAD: begin
          if (vertex_y > top_y) begin
            top_y <= vertex_y;
          end
          sweep_phase <= PH_IDLE;
        end
        DP_BUILD_INIT: begin
          ei                 <= '0;
          left_chain_index   <= IDX_W'(1);
          right_chain_offset <= '0;
          sweep_forward      <= 1'b1;
          point_counter      <= '0;
        end
        DP_EDGE_FIX, DP_EDGE_WR: ei <= ei + 1'b1;
        DP_ROW_INIT: begin
          if (row0_next > ROW_MAX) begin
            sweep_phase <= PH_DONE;
          end else begin
            row_y       <= 32'(row0_next);
            sweep_phase <= PH_ROW_START;
          end
        end
        DP_SET_DONE: sweep_phase <= PH_DONE;
        DP_CLAMP: begin
          left_chain_index <= li_c;
          if (right_chain_offset > nm1) begin
            right_chain_offset <= nm1;
          end
        end
        DP_L_INC: left_chain_index <= left_chain_index + 1'b1;
        DP_R_INC: right_chain_offset <= right_chain_offset + 1'b1;
        DP_CUT_RD_A: cut_b <= 1'b0;
        DP_CUT_RD_B: cut_b <= 1'b1;
        DP_ROW_SET: begin
          if (sweep_forward) begin
            cursor_x    <= sat32(SAT_W'(xa) + SAT_W'(d_s));
            row_limit_x <= xb;
          end else begin
            cursor_x    <= sat32(SAT_W'(xb) - SAT_W'(d_s));
            row_limit_x <= xa;
          end
          sweep_phase <= PH_IN_ROW;
        end
        DP_ROW_ADV: begin
          sweep_forward <= !sweep_forward;
          if (row_step > ROW_MAX) begin
            sweep_phase <= PH_DONE;
          end else begin
            row_y       <= 32'(row_step);
            sweep_phase <= PH_ROW_START;
          end
        end
        DP_EMIT_PT: begin
          if (point_counter != '1) begin
            point_counter <= point_counter + 1'b1;
          end
          if (sweep_forward) begin
            cursor_x <= sat32(SAT_W'(cursor_x) + SAT_W'(d_s));
          end else begin
            cursor_x <= sat32(SAT_W'(cursor_x) - SAT_W'(d_s));
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == DP_EMIT_PT) begin
      route_x     <= cursor_x;
      route_y     <= row_y;
      route_index <= point_counter;
      route_done  <= 1'b0;
    end else if (cmd == DP_EMIT_DONE) begin
      route_x     <= '0;
      route_y     <= '0;
      route_index <= point_counter;
      route_done  <= 1'b1;
    end
  end

  always_comb begin
    status.phase      = sweep_phase;
    status.row_ge_top = (row_y >= top_y);
    status.edge_fixed = ei_out || (xj == xi);
    status.ei_last    = (ei == IDX_W'(MAX_CORNERS - 1));
    status.div_done   = div_done;
    status.div_busy   = div_busy;
    status.l_more     = (left_chain_index < nm1) && (rd_y < row_y);
    status.r_more     = (right_chain_offset < nm1) && (rd_y < row_y);
    status.cut_fixed  = e_rd.vertical || (e_rd.slope == 32'sd0);
    status.cut_b      = cut_b;
    status.in_row_go  = sweep_forward ? (cursor_x < row_limit_x) : (cursor_x > row_limit_x);
    status.out_free   = !out_valid || !out_stall;
  end

endmodule

// ----- sv/psw_ctrl.sv -----
module psw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                op,
  output logic                in_stall,
  input  psw_pkg::dp_status_t status,
  output psw_pkg::dp_op_t     cmd
);
  import psw_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && op) begin
          state_next = (status.phase == PH_IDLE) ? S_B_RD_I : S_DISPATCH;
        end
      end
      S_B_RD_I:  state_next = S_B_RD_J;
      S_B_RD_J:  state_next = S_B_CAP_J;
      S_B_CAP_J: state_next = S_B_DEC;
      S_B_DEC: begin
        if (status.edge_fixed) begin
          state_next = status.ei_last ? S_ROW_INIT : S_B_RD_I;
        end else begin
          state_next = S_B_WAIT;
        end
      end
      S_B_WAIT: begin
        if (status.div_done) begin
          state_next = S_B_MUL;
        end
      end
      S_B_MUL:    state_next = S_B_WR;
      S_B_WR:     state_next = status.ei_last ? S_ROW_INIT : S_B_RD_I;
      S_ROW_INIT: state_next = S_DISPATCH;
      S_DISPATCH: begin
        unique case (status.phase)
          PH_ROW_START: state_next = status.row_ge_top ? S_EMIT_DONE : S_L_RD;
          PH_IN_ROW:    state_next = status.in_row_go ? S_EMIT_PT : S_DISPATCH;
          PH_IDLE, PH_DONE: state_next = S_EMIT_DONE;
        endcase
      end
      S_L_RD:  state_next = S_L_CHK;
      S_L_CHK: state_next = status.l_more ? S_L_RD : S_R_RD;
      S_R_RD:  state_next = S_R_CHK;
      S_R_CHK: state_next = status.r_more ? S_R_RD : S_C_DEC;
      S_C_DEC: begin
        if (status.cut_fixed) begin
          state_next = status.cut_b ? S_ROW_SET : S_C_RD_B;
        end else begin
          state_next = S_C_WAIT;
        end
      end
      S_C_WAIT: begin
        if (status.div_done) begin
          state_next = status.cut_b ? S_ROW_SET : S_C_RD_B;
        end
      end
      S_C_RD_B:  state_next = S_C_DEC;
      S_ROW_SET: state_next = S_DISPATCH;
      S_EMIT_PT, S_EMIT_DONE: begin
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = DP_NOP;
    in_stall = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (!op) begin
            cmd = DP_LOAD;
          end else if (status.phase == PH_IDLE) begin
            cmd = DP_BUILD_INIT;
          end
        end
      end
      S_B_RD_I:  cmd = DP_RD_I;
      S_B_RD_J:  cmd = DP_RD_J;
      S_B_CAP_J: cmd = DP_CAP_J;
      S_B_DEC:   cmd = status.edge_fixed ? DP_EDGE_FIX : DP_DIV_SLOPE;
      S_B_WAIT: begin
        if (status.div_done) begin
          cmd = DP_SLOPE_CAP;
        end
      end
      S_B_MUL:    cmd = DP_MUL;
      S_B_WR:     cmd = DP_EDGE_WR;
      S_ROW_INIT: cmd = DP_ROW_INIT;
      S_DISPATCH: begin
        unique case (status.phase)
          PH_ROW_START: cmd = status.row_ge_top ? DP_SET_DONE : DP_CLAMP;
          PH_IN_ROW:    cmd = status.in_row_go ? DP_NOP : DP_ROW_ADV;
          PH_IDLE, PH_DONE: cmd = DP_NOP;
        endcase
      end
      S_L_RD:  cmd = DP_L_RD;
      S_L_CHK: cmd = status.l_more ? DP_L_INC : DP_NOP;
      S_R_RD:  cmd = DP_R_RD;
      S_R_CHK: cmd = status.r_more ? DP_R_INC : DP_CUT_RD_A;
      S_C_DEC: cmd = status.cut_fixed ? DP_CUT_FIX : DP_DIV_CUT;
      S_C_WAIT: begin
        if (status.div_done) begin
          cmd = DP_CUT_CAP;
        end
      end
      S_C_RD_B:  cmd = DP_CUT_RD_B;
      S_ROW_SET: cmd = DP_ROW_SET;
      S_EMIT_PT: begin
        if (status.out_free) begin
          cmd = DP_EMIT_PT;
        end
      end
      S_EMIT_DONE: begin
        if (status.out_free) begin
          cmd = DP_EMIT_DONE;
        end
      end
      default: cmd = DP_NOP;
    endcase
  end

endmodule
